[sv/ssb_pkg.sv]
// Shared types, constants and sort-key function for the sprite sort and batch block.
package ssb_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int VERTS_PER_QUAD  = 6;

    localparam int TEX_W  = 16;
    localparam int DEP_W  = 16;
    localparam int SLOT_W = 6;
    localparam int VOFS_W = 9;
    localparam int MODE_W = 2;
    localparam int KEY_W  = 16;

    localparam logic [MODE_W-1:0] MODE_DEPTH_DESC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEPTH_ASC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEX_ASC    = 2'd2;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic clear;       // drop the running best, start a new pass
        logic cand_valid;  // read data this cycle is a candidate
    } sel_ctl_t;

    // Smaller key goes out first; depth is biased so unsigned order is signed order.
    function automatic logic [KEY_W-1:0] sort_key(
        input logic [MODE_W-1:0] mode,
        input logic [TEX_W-1:0]  tex,
        input logic [DEP_W-1:0]  dep
    );
        logic [KEY_W-1:0] biased;
        biased = dep ^ 16'h8000;
        case (mode)
            MODE_DEPTH_DESC: sort_key = ~biased;
            MODE_DEPTH_ASC:  sort_key = biased;
            MODE_TEX_ASC:    sort_key = tex;
            default:         sort_key = '0;
        endcase
    endfunction

endpackage

[sv/ssb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ssb_select.sv]
// Shared compare unit: tracks the smallest {key, slot} above the last one emitted.
module ssb_select import ssb_pkg::*; #(
    parameter int AW = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sel_ctl_t              ctl,
    input  logic [MODE_W-1:0]     mode,
    input  logic [AW-1:0]         cand_slot,
    input  logic [TEX_W-1:0]      cand_tex,
    input  logic [DEP_W-1:0]      cand_dep,
    input  logic                  have_last,
    input  logic [KEY_W+AW-1:0]   last_comp,
    output logic [KEY_W+AW-1:0]   best_comp,
    output logic [TEX_W-1:0]      best_tex,
    output logic [DEP_W-1:0]      best_dep
);

    logic                best_valid_reg, best_valid_next;
    logic [KEY_W+AW-1:0] best_comp_reg;
    logic [TEX_W-1:0]    best_tex_reg;
    logic [DEP_W-1:0]    best_dep_reg;
    logic [KEY_W+AW-1:0] cand_comp;
    logic                take;

    // slot in the low bits makes every composite unique and keeps ties stable
    assign cand_comp = {sort_key(mode, cand_tex, cand_dep), cand_slot};

    assign take = ctl.cand_valid
               && (!have_last || (cand_comp > last_comp))
               && (!best_valid_reg || (cand_comp < best_comp_reg));

    always_comb begin
        best_valid_next = best_valid_reg;
        if (ctl.clear) begin
            best_valid_next = 1'b0;
        end else if (take) begin
            best_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_valid_reg <= 1'b0;
        end else begin
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !ctl.clear) begin
            best_comp_reg <= cand_comp;
            best_tex_reg  <= cand_tex;
            best_dep_reg  <= cand_dep;
        end
    end

    assign best_comp = best_comp_reg;
    assign best_tex  = best_tex_reg;
    assign best_dep  = best_dep_reg;

endmodule

[sv/sprite_sort_and_batch.sv]
// Top level of the sprite sort and batch block: entry store, sequencer and output register.
//
// Add items (kind 0) are taken one per cycle while s_ready is high (the block is
// idle) and written to the entry store in arrival order; once MAX_ENTRIES entries
// are held, further adds are dropped and the overflow flag is raised on the last
// result of the next flush. A flush item (kind 1) sorts by sort_mode (0 depth
// descending, 1 depth ascending, 2 texture ascending, 3 arrival order) with ties
// kept in arrival order, and emits one transfer per stored entry. The sort is a
// selection over the store: each output position costs a full pass that reads
// every entry through the single RAM read port into one shared compare unit, so
// a flush of n entries keeps s_ready low for n passes of n reads, each followed by
// a drain state and an emit state that waits while m_ready stalls. A flush of an
// empty store gives no transfer. The last result is held in an output register, so
// the next add can be taken while it still waits for m_ready. sort_mode is written
// through cfg_we/cfg_wdata and should only change while the block is idle.
module sprite_sort_and_batch import ssb_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic [MODE_W-1:0]        cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [TEX_W-1:0]         s_texture_id,
    input  logic signed [DEP_W-1:0]  s_depth_key,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SLOT_W-1:0]        m_entry_slot,
    output logic [TEX_W-1:0]         m_entry_texture,
    output logic signed [DEP_W-1:0]  m_entry_depth,
    output logic                     m_opens_batch,
    output logic [VOFS_W-1:0]        m_vertex_offset,
    output logic                     m_overflowed,
    output logic                     m_last_entry
);

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = KEY_W + AW;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // taking adds and flushes
    localparam logic [1:0] ST_SCAN  = 2'd1;  // issuing store reads for one pass
    localparam logic [1:0] ST_DRAIN = 2'd2;  // last read of the pass reaches the compare
    localparam logic [1:0] ST_EMIT  = 2'd3;  // winner goes to the output register

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [MODE_W-1:0] mode_reg;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     cand_slot_reg;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [VOFS_W-1:0] vofs_reg, vofs_next;
    logic              have_last_reg, have_last_next;
    logic [CMP_W-1:0]  last_comp_reg;
    logic [TEX_W-1:0]  prev_tex_reg;

    logic              m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] m_slot_reg;
    logic [TEX_W-1:0]  m_tex_reg;
    logic [DEP_W-1:0]  m_dep_reg;
    logic              m_opens_reg;
    logic [VOFS_W-1:0] m_vofs_reg;
    logic              m_ovf_reg;
    logic              m_last_reg;

    logic              in_xfer;
    logic              out_free;
    logic              load_out;
    logic              is_last;
    logic              ram_we;
    logic [TEX_W+DEP_W-1:0] ram_rdata;
    sel_ctl_t          sel_ctl;
    logic [CMP_W-1:0]  best_comp;
    logic [TEX_W-1:0]  best_tex;
    logic [DEP_W-1:0]  best_dep;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == ST_EMIT) && out_free;
    assign is_last  = ((CW'(pos_reg) + CW'(1)) == count_reg);
    assign ram_we   = in_xfer && (s_kind == KIND_ADD) && (count_reg < CW'(MAX_ENTRIES));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = 1'b0;
        pos_next       = pos_reg;
        vofs_next      = vofs_reg;
        have_last_next = have_last_reg;
        sel_ctl        = '0;
        sel_ctl.cand_valid = pend_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_kind == KIND_ADD) begin
                        if (ram_we) begin
                            count_next = count_reg + CW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end else if (count_reg != '0) begin
                        state_next     = ST_SCAN;
                        rd_idx_next    = '0;
                        pos_next       = '0;
                        vofs_next      = '0;
                        have_last_next = 1'b0;
                        sel_ctl.clear  = 1'b1;
                    end else begin
                        // empty flush: nothing to emit, drop any stale overflow
                        ovf_next = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                pend_next = 1'b1;
                if ((CW'(rd_idx_reg) + CW'(1)) == count_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    have_last_next = 1'b1;
                    pos_next       = pos_reg + AW'(1);
                    vofs_next      = vofs_reg + VOFS_W'(VERTS_PER_QUAD);
                    sel_ctl.clear  = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        state_next  = ST_SCAN;
                        rd_idx_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            mode_reg      <= MODE_TEX_ASC;
            pend_reg      <= 1'b0;
            have_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            pend_reg      <= pend_next;
            have_last_reg <= have_last_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        cand_slot_reg <= rd_idx_reg;
        pos_reg       <= pos_next;
        vofs_reg      <= vofs_next;
        if (load_out) begin
            last_comp_reg <= best_comp;
            prev_tex_reg  <= best_tex;
            m_slot_reg    <= SLOT_W'(best_comp[AW-1:0]);
            m_tex_reg     <= best_tex;
            m_dep_reg     <= best_dep;
            m_opens_reg   <= (pos_reg == '0) || (best_tex != prev_tex_reg);
            m_vofs_reg    <= vofs_reg;
            m_ovf_reg     <= is_last && ovf_reg;
            m_last_reg    <= is_last;
        end
    end

    ssb_ram #(
        .WIDTH (TEX_W + DEP_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({s_texture_id, s_depth_key}),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    ssb_select #(
        .AW (AW)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (sel_ctl),
        .mode      (mode_reg),
        .cand_slot (cand_slot_reg),
        .cand_tex  (ram_rdata[TEX_W+DEP_W-1:DEP_W]),
        .cand_dep  (ram_rdata[DEP_W-1:0]),
        .have_last (have_last_reg),
        .last_comp (last_comp_reg),
        .best_comp (best_comp),
        .best_tex  (best_tex),
        .best_dep  (best_dep)
    );

    assign m_valid         = m_valid_reg;
    assign m_entry_slot    = m_slot_reg;
    assign m_entry_texture = m_tex_reg;
    assign m_entry_depth   = m_dep_reg;
    assign m_opens_batch   = m_opens_reg;
    assign m_vertex_offset = m_vofs_reg;
    assign m_overflowed    = m_ovf_reg;
    assign m_last_entry    = m_last_reg;

endmodule
